// File: hdl/mra_pkg.sv
// Shared constants, helper function and control types of the mean/RMS accumulator.
package mra_pkg;

  localparam int MAX_SAMPLES_DEF = 512;
  localparam int SAMPLE_BITS_DEF = 24;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // request to the shared shift-subtract unit
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } mra_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mra_stat_t;

endpackage

// File: hdl/mra_divsqrt.sv
// Shared shift-subtract unit: restoring divide by the count, or bit-pair integer root.
module mra_divsqrt #(
  parameter int SAMPLE_BITS = mra_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = 10,
  localparam int XW = mra_pkg::max_int(2 * SAMPLE_BITS - 2 + COUNT_BITS, 2 * SAMPLE_BITS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mra_pkg::mra_ctl_t     ctl_i,
  input  logic [XW-1:0]         operand_i,
  input  logic [COUNT_BITS-1:0] divisor_i,
  output mra_pkg::mra_stat_t    stat_o,
  output logic [XW-1:0]         result_o
);
  import mra_pkg::*;

  localparam int RW = max_int(COUNT_BITS + 1, SAMPLE_BITS + 2);
  localparam int CW = $clog2(XW + 1);

  logic [RW-1:0] r_q;
  logic [XW-1:0] q_q;
  logic [XW-1:0] x_q;
  logic          sqrt_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [RW-1:0] r_shift;
  logic [RW-1:0] trial;
  logic [RW:0]   diff;
  logic          ge;

  always_comb begin
    if (sqrt_q) begin
      r_shift = {r_q[RW-3:0], x_q[XW-1 -: 2]};
      trial   = {q_q[RW-3:0], 2'b01};
    end else begin
      r_shift = {r_q[RW-2:0], x_q[XW-1]};
      trial   = RW'(divisor_i);
    end
    diff = {1'b0, r_shift} - {1'b0, trial};
    ge   = ~diff[RW];
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      cnt_d  = ctl_i.sqrt_mode ? CW'(SAMPLE_BITS) : CW'(XW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      r_q    <= '0;
      q_q    <= '0;
      x_q    <= operand_i;
      sqrt_q <= ctl_i.sqrt_mode;
    end else if (busy_q) begin
      r_q <= ge ? diff[RW-1:0] : r_shift;
      q_q <= {q_q[XW-2:0], ge};
      x_q <= sqrt_q ? (x_q << 2) : (x_q << 1);
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = q_q;

endmodule

// File: hdl/mean_rms_accumulator_top.sv
// Mean and RMS spread of sample runs: accumulator, sequencer and result register.
// Samples are taken one per cycle while the block accumulates; the request carrying
// the last mark starts the end-of-run work and the input stalls until it is done.
// That work runs on one shared shift-subtract unit, one bit (divide) or one bit pair
// (root) per cycle: it divides |sum| by n, then square_sum by n, then takes the root,
// with sequencing, done handover and the mean-squared multiply between the steps;
// the input stalls until the result enters a free output register. The divides
// work on XW = max(2*SAMPLE_BITS-2+COUNT_BITS, 2*SAMPLE_BITS) bit operands.
// A finished result waits in the output register while the next run accumulates.
// Samples beyond MAX_SAMPLES in a run are dropped; the spread saturates at
// 2^(SAMPLE_BITS-1)-1.
module mean_rms_accumulator_top #(
  parameter int MAX_SAMPLES = mra_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = mra_pkg::SAMPLE_BITS_DEF,
  localparam int COUNT_BITS = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] mean_o,
  output logic [SAMPLE_BITS-2:0] spread_o,
  output logic [COUNT_BITS-1:0]  sample_count_o
);
  import mra_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int CB     = COUNT_BITS;
  localparam int SUM_W  = SB + CB;
  localparam int PROD_W = 2 * SB - 1;
  localparam int SQ_W   = 2 * SB - 2 + CB;
  localparam int XW     = max_int(SQ_W, 2 * SB);

  localparam logic [2:0] ST_ACC       = 3'd0;
  localparam logic [2:0] ST_DIVS_GO   = 3'd1;
  localparam logic [2:0] ST_DIVS_WAIT = 3'd2;
  localparam logic [2:0] ST_DIVQ_WAIT = 3'd3;
  localparam logic [2:0] ST_MUL       = 3'd4;
  localparam logic [2:0] ST_SQRT_GO   = 3'd5;
  localparam logic [2:0] ST_SQRT_WAIT = 3'd6;
  localparam logic [2:0] ST_PUSH      = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]  sq_q;
  logic [CB-1:0]    count_q;
  logic             out_valid_q, out_valid_d;

  logic [SB-1:0]     mmag_q;
  logic [SB-1:0]     mean_q;
  logic [PROD_W-1:0] msq_q;
  logic [PROD_W-1:0] sqm_q;
  logic [SB-2:0]     root_q;

  logic [SB-1:0]     mean_out_q;
  logic [SB-2:0]     spread_out_q;
  logic [CB-1:0]     count_out_q;

  logic              accept;
  logic              take;
  logic              push;
  logic [SB-1:0]     smag;
  logic [SB-1:0]     mul_a;
  logic [2*SB-1:0]   prod;
  logic [SUM_W-1:0]  sum_mag;
  logic [PROD_W-1:0] var_v;
  logic [SB-1:0]     root_raw;
  logic [SB-1:0]     qmag;

  mra_ctl_t          ctl;
  mra_stat_t         stat;
  logic [XW-1:0]     operand;
  logic [XW-1:0]     result;

  assign in_stall_o = (state_q != ST_ACC);
  assign accept     = in_valid_i && !in_stall_o;
  assign take       = accept && (count_q < CB'(MAX_SAMPLES));
  assign push       = (state_q == ST_PUSH) && (!out_valid_q || !out_stall_i);

  assign smag    = sample_i[SB-1] ? (~sample_i + 1'b1) : sample_i;
  assign mul_a   = (state_q == ST_MUL) ? mmag_q : smag;
  assign prod    = (2 * SB)'(mul_a) * (2 * SB)'(mul_a);
  assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
  assign var_v   = (msq_q >= sqm_q) ? (msq_q - sqm_q) : (sqm_q - msq_q);
  assign root_raw = result[SB-1:0];
  assign qmag     = result[SB-1:0];

  // one request to the shared unit per phase
  always_comb begin
    ctl       = '0;
    operand   = '0;
    unique case (state_q)
      ST_DIVS_GO: begin
        ctl.start = 1'b1;
        operand   = XW'(sum_mag);
      end
      ST_DIVS_WAIT: begin
        ctl.start = stat.done;
        operand   = XW'(sq_q);
      end
      ST_SQRT_GO: begin
        ctl.start     = 1'b1;
        ctl.sqrt_mode = 1'b1;
        // operand aligned to the top so the root takes SB bit pairs
        operand       = XW'({1'b0, var_v}) << (XW - 2 * SB);
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  mra_divsqrt #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_divsqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .operand_i(operand),
    .divisor_i(count_q),
    .stat_o   (stat),
    .result_o (result)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC:       if (accept && last_i) state_d = ST_DIVS_GO;
      ST_DIVS_GO:   state_d = ST_DIVS_WAIT;
      ST_DIVS_WAIT: if (stat.done) state_d = ST_DIVQ_WAIT;
      ST_DIVQ_WAIT: if (stat.done) state_d = ST_MUL;
      ST_MUL:       state_d = ST_SQRT_GO;
      ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (stat.done) state_d = ST_PUSH;
      ST_PUSH:      if (push) state_d = ST_ACC;
      default:      state_d = ST_ACC;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (push) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      sum_q       <= '0;
      sq_q        <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (push) begin
        sum_q   <= '0;
        sq_q    <= '0;
        count_q <= '0;
      end else if (take) begin
        sum_q   <= sum_q + {{CB{sample_i[SB-1]}}, sample_i};
        sq_q    <= sq_q + SQ_W'(prod[PROD_W-1:0]);
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIVS_WAIT && stat.done) begin
      mmag_q <= qmag;
      mean_q <= sum_q[SUM_W-1] ? (~qmag + 1'b1) : qmag;
    end
    if (state_q == ST_DIVQ_WAIT && stat.done) begin
      msq_q <= result[PROD_W-1:0];
    end
    if (state_q == ST_MUL) begin
      sqm_q <= prod[PROD_W-1:0];
    end
    if (state_q == ST_SQRT_WAIT && stat.done) begin
      root_q <= root_raw[SB-1] ? '1 : root_raw[SB-2:0];
    end
    if (push) begin
      mean_out_q   <= mean_q;
      spread_out_q <= root_q;
      count_out_q  <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mean_o         = mean_out_q;
  assign spread_o       = spread_out_q;
  assign sample_count_o = count_out_q;

endmodule
